// ===== rtl/core/hbs_pkg.sv =====
// Shared types, constants and helpers for the bilinear height sampler.
// Used by hbs_bank, hbs_blend and bilinear_height_sampler; no dependencies.

package hbs_pkg;

   // default geometry
   localparam int MAP_WIDTH_LOG2_DEF  = 8;
   localparam int MAP_HEIGHT_LOG2_DEF = 8;
   localparam int COORD_BITS_DEF      = 16;

   // fixed field widths
   localparam int ADDR_W      = 16;
   localparam int TEXEL_W     = 8;
   localparam int COORD_W     = 16;
   localparam int HEIGHT_W    = 16;
   localparam int BANK_ADDR_W = ADDR_W - 2;
   localparam int NUM_BANKS   = 4;

   // request kinds carried in req_tuser
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // write port of one bank
   typedef struct packed {
      logic                   en;
      logic [BANK_ADDR_W-1:0] addr;
      logic [TEXEL_W-1:0]     data;
   } bank_wr_type;

   // four neighbors of one sample, in map order
   typedef struct packed {
      logic [TEXEL_W-1:0] t00;
      logic [TEXEL_W-1:0] t01;
      logic [TEXEL_W-1:0] t10;
      logic [TEXEL_W-1:0] t11;
   } texel_quad_type;

   // Drop address bit 0 (column parity) and bit w (row parity) to get the
   // word address inside a bank.
   function automatic logic [BANK_ADDR_W-1:0] bank_addr(
      input logic [ADDR_W-1:0] a,
      input int unsigned       w
   );
      logic [BANK_ADDR_W-1:0] res;
      int unsigned            k;
      res = '0;
      k   = 0;
      for (int unsigned j = 1; j < ADDR_W; j++) begin
         if (j != w) begin
            res[k[3:0]] = a[j];
            k = k + 1;
         end
      end
      return res;
   endfunction

   // bank that holds a texel: {row parity, column parity}
   function automatic logic [1:0] bank_sel(
      input logic [ADDR_W-1:0] a,
      input int unsigned       w
   );
      return {a[w[3:0]], a[0]};
   endfunction

endpackage

// ===== rtl/core/bilinear_height_sampler.sv =====
// Top level of the bilinear height sampler: request decode, four-bank
// texel store and the blend pipeline. Depends on hbs_pkg, hbs_bank, hbs_blend.
//
// Usage:
//   req_ channel: req_tuser selects the kind (0 writes a texel, 1 samples).
//     Write transactions store texel_value at texel_index and give no
//     response. Sample transactions give exactly one rsp_ transaction.
//   rsp_ channel: rsp_tdata carries the blended height in Q8.8, truncated.
//   The map is split into four banks by row and column parity, so the four
//   neighbors of a sample are read in the same cycle from one port each.
//   Throughput: one transaction per cycle while req_tready holds high;
//     writes and samples mixed freely. A sample reaches rsp_tvalid through
//     the bank read at acceptance, then column lerp, row products, sum.
//   A sample right after a write sees the new texel; the write lands at the
//   edge that accepts it, before the next read.
//   Reset clears the pipeline valid bits only; the map holds no defined
//   values until written, so there is no clearing pass.
//   Receiver stall: each pipeline stage keeps accepting while the slot
//   ahead of it is free; req_tready drops only when every stage is full.

module bilinear_height_sampler #(
   parameter int MAP_WIDTH_LOG2  = hbs_pkg::MAP_WIDTH_LOG2_DEF,
   parameter int MAP_HEIGHT_LOG2 = hbs_pkg::MAP_HEIGHT_LOG2_DEF,
   parameter int COORD_BITS      = hbs_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] texel_index, [23:16] texel_value, [39:24] u_coord, [55:40] v_coord
   input  logic [55:0] req_tdata,
   // [0] op
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] sample_height
   output logic [15:0] rsp_tdata
);

   localparam int W       = MAP_WIDTH_LOG2;
   localparam int H       = MAP_HEIGHT_LOG2;
   localparam int FC_BITS = COORD_BITS - W;
   localparam int FR_BITS = COORD_BITS - H;

   logic [hbs_pkg::ADDR_W-1:0]  texel_index;
   logic [hbs_pkg::TEXEL_W-1:0] texel_value;
   logic [COORD_BITS-1:0]       u_c, v_c;
   logic [W-1:0]                col, col1;
   logic [H-1:0]                row, row1;
   logic                        accept, rd_en;
   logic                        blend_ready;

   logic [hbs_pkg::TEXEL_W-1:0]     bank_rd_data [hbs_pkg::NUM_BANKS];
   hbs_pkg::texel_quad_type     texels;

   // stage 1: bank read in flight
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_rpar_ff, s1_cpar_ff;
   logic [FC_BITS-1:0] s1_fc_ff;
   logic [FR_BITS-1:0] s1_fr_ff;

   // unpack the request and split the coordinates
   always_comb begin
      texel_index = req_tdata[15:0];
      texel_value = req_tdata[23:16];
      u_c  = COORD_BITS'(req_tdata[39:24]);
      v_c  = COORD_BITS'(req_tdata[55:40]);
      col  = u_c[COORD_BITS-1 -: W];
      row  = v_c[COORD_BITS-1 -: H];
      col1 = col + W'(1);
      row1 = row + H'(1);
   end

   assign req_tready = !s1_valid_ff || blend_ready;
   assign accept     = req_tvalid && req_tready;
   assign rd_en      = accept && (req_tuser == hbs_pkg::OP_SAMPLE);

   // one bank per {row parity, column parity}
   for (genvar b = 0; b < hbs_pkg::NUM_BANKS; b++) begin : g_bank
      logic [H-1:0]                    r_sel;
      logic [W-1:0]                    c_sel;
      logic [hbs_pkg::ADDR_W-1:0]      rd_full;
      hbs_pkg::bank_wr_type            bank_wr;
      logic [hbs_pkg::BANK_ADDR_W-1:0] bank_rd_addr;

      // pick the neighbor that falls in this bank
      always_comb begin
         r_sel   = (row[0] == b[1]) ? row : row1;
         c_sel   = (col[0] == b[0]) ? col : col1;
         rd_full = hbs_pkg::ADDR_W'({r_sel, c_sel});
         bank_rd_addr = hbs_pkg::bank_addr(rd_full, W);
         bank_wr.en   = accept && (req_tuser == hbs_pkg::OP_WRITE)
                     && (hbs_pkg::bank_sel(texel_index, W) == 2'(b));
         bank_wr.addr = hbs_pkg::bank_addr(texel_index, W);
         bank_wr.data = texel_value;
      end

      hbs_bank u_bank (
         .clock   (clock),
         .wr      (bank_wr),
         .rd_en   (rd_en),
         .rd_addr (bank_rd_addr),
         .rd_data (bank_rd_data[b])
      );
   end

   // track the sample whose texels are being read
   assign s1_valid_in = rd_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_rpar_ff <= row[0];
         s1_cpar_ff <= col[0];
         s1_fc_ff   <= u_c[FC_BITS-1:0];
         s1_fr_ff   <= v_c[FR_BITS-1:0];
      end
   end

   // route bank outputs back to neighbor order
   always_comb begin
      texels.t00 = bank_rd_data[{s1_rpar_ff,  s1_cpar_ff}];
      texels.t01 = bank_rd_data[{s1_rpar_ff, !s1_cpar_ff}];
      texels.t10 = bank_rd_data[{!s1_rpar_ff,  s1_cpar_ff}];
      texels.t11 = bank_rd_data[{!s1_rpar_ff, !s1_cpar_ff}];
   end

   hbs_blend #(
      .MAP_WIDTH_LOG2  (MAP_WIDTH_LOG2),
      .MAP_HEIGHT_LOG2 (MAP_HEIGHT_LOG2),
      .COORD_BITS      (COORD_BITS)
   ) u_blend (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (blend_ready),
      .texels     (texels),
      .frac_c     (s1_fc_ff),
      .frac_r     (s1_fr_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/hbs_bank.sv =====
// One quarter of the height map: 16K x 8 synchronous RAM, one write and
// one registered read port. Depends on hbs_pkg.

module hbs_bank (
   input  logic                                clock,
   input  hbs_pkg::bank_wr_type                wr,
   input  logic                                rd_en,
   input  logic [hbs_pkg::BANK_ADDR_W-1:0]     rd_addr,
   output logic [hbs_pkg::TEXEL_W-1:0]         rd_data
);

   logic [hbs_pkg::TEXEL_W-1:0] mem [2**hbs_pkg::BANK_ADDR_W];
   logic [hbs_pkg::TEXEL_W-1:0] rd_data_ff;

   // store a texel
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read, hold data while no new read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/hbs_blend.sv =====
// Bilinear blend pipeline: horizontal lerps, vertical products, sum and
// Q8.8 alignment, with per-stage valid and a ready chain. Depends on hbs_pkg.

module hbs_blend #(
   parameter int MAP_WIDTH_LOG2  = hbs_pkg::MAP_WIDTH_LOG2_DEF,
   parameter int MAP_HEIGHT_LOG2 = hbs_pkg::MAP_HEIGHT_LOG2_DEF,
   parameter int COORD_BITS      = hbs_pkg::COORD_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   output logic                                          in_ready,
   input  hbs_pkg::texel_quad_type                       texels,
   input  logic [COORD_BITS-MAP_WIDTH_LOG2-1:0]          frac_c,
   input  logic [COORD_BITS-MAP_HEIGHT_LOG2-1:0]         frac_r,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [hbs_pkg::HEIGHT_W-1:0]                  rsp_tdata
);

   localparam int FC_BITS  = COORD_BITS - MAP_WIDTH_LOG2;
   localparam int FR_BITS  = COORD_BITS - MAP_HEIGHT_LOG2;
   localparam int SUM_BITS = FC_BITS + FR_BITS;
   localparam int TOP_W    = hbs_pkg::TEXEL_W + FC_BITS;
   localparam int TOT_W    = hbs_pkg::TEXEL_W + SUM_BITS;
   localparam int SH_R     = (SUM_BITS >= 8) ? SUM_BITS - 8 : 0;
   localparam int SH_L     = (SUM_BITS < 8) ? 8 - SUM_BITS : 0;

   // stage 2: horizontal lerps
   logic               s2_valid_ff, s2_valid_in;
   logic [TOP_W-1:0]   s2_top_ff, s2_top_in;
   logic [TOP_W-1:0]   s2_bot_ff, s2_bot_in;
   logic [FR_BITS-1:0] s2_fr_ff;
   // stage 3: vertical products
   logic               s3_valid_ff, s3_valid_in;
   logic [TOT_W-1:0]   s3_ptop_ff, s3_ptop_in;
   logic [TOT_W-1:0]   s3_pbot_ff, s3_pbot_in;
   // stage 4: output register
   logic                         s4_valid_ff, s4_valid_in;
   logic [hbs_pkg::HEIGHT_W-1:0] s4_height_ff, s4_height_in;

   logic               rdy2, rdy3, rdy4;
   logic [FC_BITS:0]   wc0;
   logic [FR_BITS:0]   wr0;
   logic [TOT_W-1:0]   total;
   logic [TOT_W+7:0]   total_wide;

   // ready chain: a stage moves when its slot is empty or drains
   assign rdy4     = !s4_valid_ff || rsp_tready;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign in_ready = rdy2;

   // lerp across columns
   always_comb begin
      wc0 = {1'b1, {FC_BITS{1'b0}}} - (FC_BITS+1)'(frac_c);
      s2_top_in = TOP_W'((TOP_W+1)'(texels.t00) * (TOP_W+1)'(wc0)
                       + (TOP_W+1)'(texels.t01) * (TOP_W+1)'(frac_c));
      s2_bot_in = TOP_W'((TOP_W+1)'(texels.t10) * (TOP_W+1)'(wc0)
                       + (TOP_W+1)'(texels.t11) * (TOP_W+1)'(frac_c));
      s2_valid_in = in_valid;
   end

   // weight the two rows
   always_comb begin
      wr0 = {1'b1, {FR_BITS{1'b0}}} - (FR_BITS+1)'(s2_fr_ff);
      s3_ptop_in  = TOT_W'(TOT_W'(s2_top_ff) * TOT_W'(wr0));
      s3_pbot_in  = TOT_W'(TOT_W'(s2_bot_ff) * TOT_W'(s2_fr_ff));
      s3_valid_in = s2_valid_ff;
   end

   // sum and align to Q8.8, dropping the extra fraction bits
   always_comb begin
      total        = s3_ptop_ff + s3_pbot_ff;
      total_wide   = {8'b0, total};
      s4_height_in = hbs_pkg::HEIGHT_W'((total_wide >> SH_R) << SH_L);
      s4_valid_in  = s3_valid_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (rdy2) s2_valid_ff <= s2_valid_in;
         if (rdy3) s3_valid_ff <= s3_valid_in;
         if (rdy4) s4_valid_ff <= s4_valid_in;
      end
   end

   // payload, loaded only when a transaction moves in
   always_ff @(posedge clock) begin
      if (rdy2 && s2_valid_in) begin
         s2_top_ff <= s2_top_in;
         s2_bot_ff <= s2_bot_in;
         s2_fr_ff  <= frac_r;
      end
      if (rdy3 && s3_valid_in) begin
         s3_ptop_ff <= s3_ptop_in;
         s3_pbot_ff <= s3_pbot_in;
      end
      if (rdy4 && s4_valid_in) begin
         s4_height_ff <= s4_height_in;
      end
   end

   assign rsp_tvalid = s4_valid_ff;
   assign rsp_tdata  = s4_height_ff;

endmodule

// ===== tb/tb_bilinear_height_sampler.sv =====
// Self-checking testbench for bilinear_height_sampler: texel writes and wrapped
// bilinear samples with random idling, predicted by a small scoreboard class.
// Depends on hbs_pkg and the bilinear_height_sampler RTL.
`timescale 1ns / 100ps

module tb_bilinear_height_sampler;

   // geometry of the instance under test
   localparam int MAP_W_LOG2 = hbs_pkg::MAP_WIDTH_LOG2_DEF;
   localparam int MAP_H_LOG2 = hbs_pkg::MAP_HEIGHT_LOG2_DEF;
   localparam int CRD_BITS   = hbs_pkg::COORD_BITS_DEF;
   localparam int FC_BITS    = CRD_BITS - MAP_W_LOG2;
   localparam int FR_BITS    = CRD_BITS - MAP_H_LOG2;
   localparam int SUM_BITS   = FC_BITS + FR_BITS;

   localparam longint unsigned COORD_MASK = (64'd1 << CRD_BITS) - 1;
   localparam int unsigned     COL_MASK   = (1 << MAP_W_LOG2) - 1;
   localparam int unsigned     ROW_MASK   = (1 << MAP_H_LOG2) - 1;
   localparam longint unsigned ADDR_MASK  = 64'hFFFF;
   localparam int unsigned     FC_MAX     = (1 << FC_BITS) - 1;
   localparam int unsigned     FR_MAX     = (1 << FR_BITS) - 1;

   // run control
   localparam int ITEM_TARGET  = 1350;
   localparam int QUIET_ITEMS  = 150;
   localparam int PRESSURE_AT  = 400;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] texel_index, [23:16] texel_value, [39:24] u_coord, [55:40] v_coord
   logic [55:0] req_tdata  = '0;
   // [0] op
   logic        req_tuser  = hbs_pkg::OP_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] sample_height
   logic [15:0] rsp_tdata;

   int          items_sent  = 0;
   int          cycle_count = 0;
   bit          quiet       = 1'b0;
   bit          hold_rsp    = 1'b0;
   bit          hold_done   = 1'b0;
   int unsigned anchors [$];

   // Mirror of the height map and the heights still owed by the block.
   class height_scoreboard;
      logic [7:0]  texel_map [0:65535];
      bit          texel_written [0:65535];
      logic [15:0] height_q [$];
      int          errors;

      function new();
         errors = 0;
         foreach (texel_map[i]) begin
            texel_map[i]     = 8'h00;
            texel_written[i] = 1'b0;
         end
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Address of one of the four neighbors, both axes wrapped.
      function logic [15:0] corner_addr(input logic [15:0] u, input logic [15:0] v,
                                        input int unsigned dr, input int unsigned dc);
         longint unsigned col, row;
         col = (((u & COORD_MASK) >> FC_BITS) + dc) & COL_MASK;
         row = (((v & COORD_MASK) >> FR_BITS) + dr) & ROW_MASK;
         return 16'(((row << MAP_W_LOG2) | col) & ADDR_MASK);
      endfunction

      function bit quad_written(input logic [15:0] u, input logic [15:0] v);
         return texel_written[corner_addr(u, v, 0, 0)] && texel_written[corner_addr(u, v, 0, 1)]
             && texel_written[corner_addr(u, v, 1, 0)] && texel_written[corner_addr(u, v, 1, 1)];
      endfunction

      // Exact blend, then align to Q8.8 by truncation.
      function logic [15:0] predict_height(input logic [15:0] u, input logic [15:0] v);
         longint unsigned one_c, one_r, fc, fr, t00, t01, t10, t11, top, bot, total;
         one_c = 64'd1 << FC_BITS;
         one_r = 64'd1 << FR_BITS;
         fc    = (u & COORD_MASK) & (one_c - 1);
         fr    = (v & COORD_MASK) & (one_r - 1);
         t00   = texel_map[corner_addr(u, v, 0, 0)];
         t01   = texel_map[corner_addr(u, v, 0, 1)];
         t10   = texel_map[corner_addr(u, v, 1, 0)];
         t11   = texel_map[corner_addr(u, v, 1, 1)];
         top   = t00 * (one_c - fc) + t01 * fc;
         bot   = t10 * (one_c - fc) + t11 * fc;
         total = top * (one_r - fr) + bot * fr;
         if (SUM_BITS >= 8) begin
            total = total >> (SUM_BITS - 8);
         end else begin
            total = total << (8 - SUM_BITS);
         end
         return total[15:0];
      endfunction

      // Apply an accepted request transaction.
      function void note_request(input logic op, input logic [55:0] data);
         if (op == hbs_pkg::OP_WRITE) begin
            texel_map[data[15:0]]     = data[23:16];
            texel_written[data[15:0]] = 1'b1;
         end else begin
            height_q.push_back(predict_height(data[39:24], data[55:40]));
         end
      endfunction

      // Compare an accepted response transaction with the oldest height owed.
      task check_response(input logic [15:0] got);
         logic [15:0] want;
         if (height_q.size() == 0) begin
            report($sformatf("response %h with no sample outstanding", got));
         end else begin
            want = height_q.pop_front();
            if (got !== want) begin
               report($sformatf("sample_height got %h want %h", got, want));
            end
         end
      endtask
   endclass

   height_scoreboard sb;

   bilinear_height_sampler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Record transactions on both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
         end
      end
   end

   // Bound the run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Receiver: random ready bursts, one long hold-off, steady at the end.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else if (quiet || $urandom_range(0, 5) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
      end
   end

   // Offer one request and hold it until accepted; idle first at random.
   task automatic send_item(input logic op, input logic [15:0] idx, input logic [7:0] val,
                            input logic [15:0] u, input logic [15:0] v);
      quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
      if (!quiet && !(hold_rsp && !hold_done) && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, u, val, idx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic logic [7:0] rand_texel();
      int unsigned pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic write_texel(input int unsigned row, input int unsigned col,
                              input logic [7:0] val);
      longint unsigned addr;
      addr = (((row & ROW_MASK) << MAP_W_LOG2) | (col & COL_MASK)) & ADDR_MASK;
      send_item(hbs_pkg::OP_WRITE, 16'(addr), val, 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)));
   endtask

   task automatic sample_at(input int unsigned row, input int unsigned col,
                            input int unsigned fu, input int unsigned fv);
      longint unsigned u, v;
      u = ((longint'(col) << FC_BITS) | fu) & COORD_MASK;
      v = ((longint'(row) << FR_BITS) | fv) & COORD_MASK;
      send_item(hbs_pkg::OP_SAMPLE, 16'($urandom_range(0, 65535)),
                8'($urandom_range(0, 255)), 16'(u), 16'(v));
   endtask

   // Sample inside a written 2x2 block with random fractions.
   task automatic sample_anchor(input int unsigned anchor);
      sample_at(anchor >> 16, anchor & 16'hFFFF, $urandom_range(0, FC_MAX),
                $urandom_range(0, FR_MAX));
   endtask

   // Well-formed sequence: fill one wrapped 2x2 block, then sample blocks.
   task automatic block_then_samples();
      int unsigned row, col, n;
      row = $urandom_range(0, int'(ROW_MASK));
      col = $urandom_range(0, int'(COL_MASK));
      write_texel(row, col, rand_texel());
      write_texel(row, col + 1, rand_texel());
      write_texel(row + 1, col, rand_texel());
      write_texel(row + 1, col + 1, rand_texel());
      anchors.push_back((row << 16) | col);
      n = $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 4) < 3) begin
            sample_anchor(anchors[anchors.size() - 1]);
         end else begin
            sample_anchor(anchors[$urandom_range(0, anchors.size() - 1)]);
         end
      end
   endtask

   // Noise: stray writes and samples at arbitrary coordinates when safe.
   task automatic noise_item();
      logic [15:0] u, v;
      u = 16'($urandom_range(0, 65535));
      v = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 1) == 0) begin
         send_item(hbs_pkg::OP_WRITE, 16'($urandom_range(0, 65535)), rand_texel(), u, v);
      end else if (sb.quad_written(u, v)) begin
         send_item(hbs_pkg::OP_SAMPLE, 16'($urandom_range(0, 65535)),
                   8'($urandom_range(0, 255)), u, v);
      end else begin
         sample_anchor(anchors[$urandom_range(0, anchors.size() - 1)]);
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Block that straddles both wrap seams, extremes of value.
      write_texel(ROW_MASK, COL_MASK, 8'h00);
      write_texel(ROW_MASK, 0, 8'hFF);
      write_texel(0, COL_MASK, 8'hFF);
      write_texel(0, 0, 8'h00);
      sample_at(ROW_MASK, COL_MASK, 0, 0);
      sample_at(ROW_MASK, COL_MASK, FC_MAX, FR_MAX);
      sample_at(ROW_MASK, COL_MASK, (FC_MAX + 1) / 2, (FR_MAX + 1) / 2);
      anchors.push_back((ROW_MASK << 16) | COL_MASK);

      // Block at the origin: zero and full fractions on each axis.
      write_texel(0, 1, 8'hFF);
      write_texel(1, 0, 8'hFF);
      write_texel(1, 1, 8'hFF);
      sample_at(0, 0, 0, 0);
      sample_at(0, 0, (FC_MAX + 1) / 2, 0);
      sample_at(0, 0, 0, FR_MAX);
      sample_at(0, 0, FC_MAX, FR_MAX);
      anchors.push_back(0);

      // Sample right after a write; all-full block gives the top height.
      write_texel(0, 0, 8'hFF);
      sample_at(0, 0, 0, 0);
      sample_at(0, 0, FC_MAX, 0);

      // Ignored fields held at all ones and all zeros.
      send_item(hbs_pkg::OP_WRITE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(hbs_pkg::OP_SAMPLE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_item(hbs_pkg::OP_SAMPLE, 16'h0000, 8'h00, 16'h0000, 16'h0000);

      // Random part, with one long receiver hold-off along the way.
      while (items_sent < ITEM_TARGET) begin
         if (!hold_rsp && items_sent >= PRESSURE_AT) begin
            hold_rsp = 1'b1;
         end
         if ($urandom_range(0, 4) != 0) begin
            block_then_samples();
         end else begin
            noise_item();
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding heights, then watch for strays.
      while (sb.height_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
